@@ hw/rtl/dcc_pkg.sv @@
package dcc_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [1:0] {
    DOM_RED,
    DOM_GREEN,
    DOM_BLUE
  } dom_t;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ALPHA_Q8     = 2'd2;

  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [8:0]  ALPHA_ONE    = 9'd256;
  localparam logic [7:0]  CHAN_MAX     = 8'd255;

  function automatic logic [7:0] max3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  function automatic logic [7:0] scale_sat(logic [7:0] v, logic [9:0] f);
    logic [17:0] p;
    p = 18'(v) * 18'(f);
    return (p[17:16] != 2'b00) ? CHAN_MAX : p[15:8];
  endfunction

endpackage

@@ hw/rtl/dcc_line_mem.sv @@
module dcc_line_mem
  import dcc_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output line_pair_t    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_pair_t    wr_data
);

  line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/dominant_channel_colorize_3x3_top.sv @@
// 3x3 dominant-channel colorize filter on a BGRA raster stream. Both lines above
// the current row live in one synchronous line memory (upper and middle pixel
// per column); each accepted pixel reads its column and the pair is written back
// as stage 1 advances, so one pixel is accepted every clock unless stalled.
// A pixel at row r >= 2, column c >= 2 produces the result for the center pixel
// (r-1, c-1) via stages 1 and 2 and the output register; border pixels produce
// nothing. tlast flags the last interior pixel of the frame. Writing the width
// or height register restarts the frame; configure only while the stream is idle.
module dominant_channel_colorize_3x3_top
  import dcc_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // in_blue, in_green, in_red, in_alpha
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_blue, out_green, out_red, out_alpha
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [13:0] MAX_W = 14'(MAX_WIDTH);

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [8:0]  alpha_q8;

  logic [13:0] eff_width;
  logic [13:0] width_m1;
  logic [12:0] eff_height;
  logic [12:0] height_m1;
  logic [COL_W-1:0] col_last;
  logic [11:0] row_last;

  logic [COL_W-1:0] col;
  logic [11:0] row;

  logic en;
  logic accept;

  logic             s1_valid;
  pixel_t           s1_px;
  logic [COL_W-1:0] s1_col;
  logic             s1_res;
  logic             s1_last;

  line_pair_t rd_data;
  line_pair_t wr_data;
  logic       proc;

  rgb_t   prev2;
  rgb_t   prev1;
  rgb_t   col_max;
  pixel_t mid_prev;
  logic [7:0] win_b;
  logic [7:0] win_g;
  logic [7:0] win_r;
  dom_t dom;

  logic   s2_valid;
  pixel_t s2_px;
  dom_t   s2_dom;
  logic   s2_last;

  logic [8:0] alpha_eff;
  logic [9:0] f_up;
  logic [9:0] f_dn;
  logic [9:0] f_blue;
  logic [9:0] f_green;
  logic [9:0] f_red;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      alpha_q8     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_ALPHA_Q8:     alpha_q8     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({2'b00, image_width} < 14'd3) begin
      eff_width = 14'd3;
    end else if ({2'b00, image_width} > MAX_W) begin
      eff_width = MAX_W;
    end else begin
      eff_width = {2'b00, image_width};
    end
    width_m1 = eff_width - 14'd1;
    col_last = width_m1[COL_W-1:0];

    if (image_height < 13'd3) begin
      eff_height = 13'd3;
    end else if (image_height > MAX_HEIGHT) begin
      eff_height = MAX_HEIGHT;
    end else begin
      eff_height = image_height;
    end
    height_m1 = eff_height - 13'd1;
    row_last  = height_m1[11:0];
  end

  // whole pipeline advances unless the output register is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == col_last) begin
        col <= '0;
        row <= (row == row_last) ? 12'd0 : row + 12'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // stage 1: line memory read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= s_tdata;
      s1_col  <= col;
      s1_res  <= (row >= 12'd2) && (col >= COL_W'(2));
      s1_last <= (row == row_last) && (col == col_last);
    end
  end

  // consecutive pixels hit different columns, so read and write-back never collide
  assign proc            = s1_valid && en;
  assign wr_data.upper   = rd_data.middle;
  assign wr_data.middle  = s1_px;

  dcc_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (proc),
    .wr_addr (s1_col),
    .wr_data (wr_data)
  );

  // stage 2: column maxima, window maxima, dominant channel
  always_comb begin
    col_max.blue  = max3(rd_data.upper.blue,  rd_data.middle.blue,  s1_px.blue);
    col_max.green = max3(rd_data.upper.green, rd_data.middle.green, s1_px.green);
    col_max.red   = max3(rd_data.upper.red,   rd_data.middle.red,   s1_px.red);
    win_b = max3(prev2.blue,  prev1.blue,  col_max.blue);
    win_g = max3(prev2.green, prev1.green, col_max.green);
    win_r = max3(prev2.red,   prev1.red,   col_max.red);
    if (win_r >= win_g && win_r >= win_b) begin
      dom = DOM_RED;
    end else if (win_g >= win_b) begin
      dom = DOM_GREEN;
    end else begin
      dom = DOM_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      prev2    <= prev1;
      prev1    <= col_max;
      mid_prev <= rd_data.middle;
      s2_px    <= mid_prev;
      s2_dom   <= dom;
      s2_last  <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_res;
    end
  end

  // stage 3: scale and saturate into the output register
  always_comb begin
    alpha_eff = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;
    f_up      = {1'b0, ALPHA_ONE} + {1'b0, alpha_eff};
    f_dn      = {1'b0, ALPHA_ONE} - {1'b0, alpha_eff};
    f_blue    = f_dn;
    f_green   = f_dn;
    f_red     = f_dn;
    case (s2_dom)
      DOM_RED:   f_red   = f_up;
      DOM_GREEN: f_green = f_up;
      DOM_BLUE:  f_blue  = f_up;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      m_tdata <= {s2_px.alpha,
                  scale_sat(s2_px.red,   f_red),
                  scale_sat(s2_px.green, f_green),
                  scale_sat(s2_px.blue,  f_blue)};
      m_tlast <= s2_last;
    end
  end

endmodule

@@ test/dominant_channel_colorize_3x3_top_test.sv @@
`timescale 1ns / 1ps

module dominant_channel_colorize_3x3_top_test;
  import dcc_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PIXELS = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } colorized_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  index;
    logic [12:0] value;
    pixel_t      pix;
    logic        known;
    colorized_t  want;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [12:0] cfg_data  = '0;

  dominant_channel_colorize_3x3_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [11:0] width_reg  = WIDTH_RESET;
  logic [12:0] height_reg = HEIGHT_RESET;
  logic [8:0]  alpha_reg  = '0;
  pixel_t      upper_row [LINE_DEPTH];
  pixel_t      middle_row [LINE_DEPTH];
  pixel_t      window [9];
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  colorized_t  pending_colorized [$];
  plan_row_t   directed_plan [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned pixels_left  = 0;
  int unsigned cycles       = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;
  bit          hold_done    = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] weigh_chan(logic [7:0] level, int unsigned factor);
    int unsigned prod;
    prod = (level * factor) >> 8;
    return (prod > 255) ? CHAN_MAX : prod[7:0];
  endfunction

  task automatic colorize_pixel(input pixel_t px, input logic known, input colorized_t want);
    int unsigned w, h, c, r, lift, damp, i;
    logic [8:0] a;
    logic [7:0] mb, mg, mr;
    pixel_t top, mid, ctr;
    dom_t dom;
    colorized_t res;
    w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    h = (height_reg < 3) ? 3 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    c = (col_pos >= w) ? 0 : col_pos;
    r = (row_pos >= h) ? 0 : row_pos;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = px;
    for (i = 0; i < 3; i++) begin
      window[i * 3]     = window[i * 3 + 1];
      window[i * 3 + 1] = window[i * 3 + 2];
    end
    window[2] = top;
    window[5] = mid;
    window[8] = px;
    if (r >= 2 && c >= 2) begin
      a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
      lift = ALPHA_ONE + a;
      damp = ALPHA_ONE - a;
      mb = '0;
      mg = '0;
      mr = '0;
      for (i = 0; i < 9; i++) begin
        if (window[i].blue > mb) mb = window[i].blue;
        if (window[i].green > mg) mg = window[i].green;
        if (window[i].red > mr) mr = window[i].red;
      end
      if (mr >= mg && mr >= mb) dom = DOM_RED;
      else if (mg >= mb) dom = DOM_GREEN;
      else dom = DOM_BLUE;
      ctr = window[4];
      res.pix.blue  = weigh_chan(ctr.blue, (dom == DOM_BLUE) ? lift : damp);
      res.pix.green = weigh_chan(ctr.green, (dom == DOM_GREEN) ? lift : damp);
      res.pix.red   = weigh_chan(ctr.red, (dom == DOM_RED) ? lift : damp);
      res.pix.alpha = ctr.alpha;
      res.last = (r == h - 1) && (c == w - 1);
      pending_colorized.push_back(known ? want : res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // only while idle: drain results, let border pixels settle, then write
  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    s_tvalid <= 1'b0;
    while (pending_colorized.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_IMAGE_WIDTH: begin
        width_reg = value[11:0];
        row_pos = 0;
        col_pos = 0;
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = value;
        row_pos = 0;
        col_pos = 0;
      end
      CFG_ALPHA_Q8: alpha_reg = value[8:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t px, input logic known, input colorized_t want);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    colorize_pixel(px, known, want);
    if (pixels_left != 0) pixels_left--;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  task automatic check_result(input pixel_t got, input logic got_last);
    colorized_t due;
    results_seen++;
    if (pending_colorized.size() == 0) begin
      $display("%0t: result with nothing expected, got %h last %b", $time, got, got_last);
      mismatches++;
    end else begin
      due = pending_colorized.pop_front();
      compare_field("blue", due.pix.blue, got.blue);
      compare_field("green", due.pix.green, got.green);
      compare_field("red", due.pix.red, got.red);
      compare_field("alpha", due.pix.alpha, got.alpha);
      compare_field("frame_end", {7'd0, due.last}, {7'd0, got_last});
    end
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = $urandom();
    case ($urandom_range(0, 3))
      1: begin
        p.blue  = {8{p.blue[0]}};
        p.green = {8{p.green[0]}};
        p.red   = {8{p.red[0]}};
      end
      2: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      3: begin
        if (p.alpha[0]) p.green = p.red;
        else p.blue = p.green;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_cfg(input logic [1:0] index, input logic [12:0] value);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.index = index;
    row.value = value;
    directed_plan.push_back(row);
  endtask

  task automatic add_pixel(input pixel_t px, input logic known, input colorized_t want);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_PIXEL;
    row.pix   = px;
    row.known = known;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  initial begin : drain
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata, m_tlast);
      // long back-pressure while the sender keeps going
      if (!hold_done && results_seen >= 100 && pixels_left > 20) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("dominant_channel_colorize_3x3_top_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, w, h, frame_px, npix, total;
    logic [8:0] alpha_set;
    colorized_t none;
    none = '0;

    // clamped 3x3 frame, all ones, alpha zero: passes through
    add_cfg(CFG_IMAGE_WIDTH, 13'd1);
    add_cfg(CFG_IMAGE_HEIGHT, 13'd0);
    add_cfg(CFG_ALPHA_Q8, 13'd0);
    repeat (8) add_pixel(32'hFFFF_FFFF, 1'b0, none);
    add_pixel(32'hFFFF_FFFF, 1'b1, {32'hFFFF_FFFF, 1'b1});
    // partial frame, then geometry write restarts it
    add_pixel(32'h8040_2010, 1'b0, none);
    add_pixel(32'h0000_0000, 1'b0, none);
    add_pixel(32'hFFFF_FFFF, 1'b0, none);
    add_pixel(32'h7F7F_7F7F, 1'b0, none);
    add_cfg(CFG_IMAGE_WIDTH, 13'd3);
    // alpha above one saturates the dominant red, zeroes the rest
    add_cfg(CFG_ALPHA_Q8, 13'd511);
    add_cfg(CFG_UNUSED, 13'h1FFF);
    repeat (4) add_pixel(32'h0000_0000, 1'b0, none);
    add_pixel(32'h5AC8_6432, 1'b0, none);
    repeat (3) add_pixel(32'h0000_0000, 1'b0, none);
    add_pixel(32'h0000_0000, 1'b1, {32'h5AFF_0000, 1'b1});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].kind == ROW_CFG)
        write_reg(directed_plan[k].index, directed_plan[k].value);
      else
        send_pixel(directed_plan[k].pix, directed_plan[k].known, directed_plan[k].want);
    end

    total = 0;
    phase = 0;
    while (total < RANDOM_PIXELS) begin
      if (phase == 1) begin
        w = 12'hFFF;
        h = 3;
        npix = $urandom_range(3, 40);
      end else if (phase == 4) begin
        w = 3;
        h = 13'h1FFF;
        npix = 3 * $urandom_range(20, 40);
      end else begin
        w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        frame_px = ((w < 3) ? 3 : w) * ((h < 3) ? 3 : h);
        npix = frame_px * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) npix += $urandom_range(1, frame_px - 1);
      end
      total += npix;
      case ($urandom_range(0, 3))
        0: alpha_set = '0;
        1: alpha_set = ALPHA_ONE;
        2: alpha_set = $urandom_range(257, 511);
        default: alpha_set = $urandom_range(0, 256);
      endcase
      // some phases keep the geometry and carry on mid-frame
      if (phase < 2 || phase == 4 || $urandom_range(0, 3) != 0) begin
        write_reg(CFG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w[11:0]});
        write_reg(CFG_IMAGE_HEIGHT, h[12:0]);
      end
      write_reg(CFG_ALPHA_Q8, {4'($urandom()), alpha_set});
      if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, 13'($urandom()));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      pixels_left = npix;
      repeat (npix) send_pixel(random_pixel(), 1'b0, none);
      phase++;
    end

    s_tvalid <= 1'b0;
    while (pending_colorized.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("dominant_channel_colorize_3x3_top_test: done, clean");
    else
      $display("dominant_channel_colorize_3x3_top_test: done, errors");
    $finish;
  end

endmodule
